FILE: rtl/ted_pkg.sv
package ted_pkg;

  localparam int POS_W    = 12;
  localparam int SAMPLE_W = 8;
  localparam int UTF8_W   = 9;
  localparam int SCORE_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [POS_W-1:0]    POS_MAX            = 12'd4095;
  localparam logic [POS_W-1:0]    SCAN_LIMIT_RESET   = 12'd1000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_LIMIT_RESET = 8'd100;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LIMIT = 2'd1;

  // byte-order marks
  localparam logic [7:0] BOM8_0 = 8'hEF;
  localparam logic [7:0] BOM8_1 = 8'hBB;
  localparam logic [7:0] BOM8_2 = 8'hBF;
  localparam logic [7:0] BOM16_FF = 8'hFF;
  localparam logic [7:0] BOM16_FE = 8'hFE;

  typedef enum logic [2:0] {
    ENC_UTF8     = 3'd0,
    ENC_UTF16LE  = 3'd1,
    ENC_UTF16BE  = 3'd2,
    ENC_ASCII    = 3'd3,
    ENC_KOI8R    = 3'd4,
    ENC_CP1251   = 3'd5
  } enc_t;

  // end-of-file view of the stream state, as seen by the decision logic
  typedef struct packed {
    logic                ge2;
    logic                ge3;
    logic [7:0]          lead0;
    logic [7:0]          lead1;
    logic [7:0]          lead2;
    logic                high_seen;
    logic [UTF8_W-1:0]   utf8;
    logic [SCORE_W-1:0]  cp1251;
    logic [SCORE_W-1:0]  koi8;
  } stream_t;

endpackage

FILE: rtl/ted_decide.sv
module ted_decide (
  input  ted_pkg::stream_t st,
  output ted_pkg::enc_t    enc
);

  localparam int SCORE_W_EXT = ted_pkg::SCORE_W + 1;

  logic [SCORE_W_EXT-1:0] cp_x2;
  logic [SCORE_W_EXT-1:0] koi_x2;

  assign cp_x2  = {st.cp1251, 1'b0};
  assign koi_x2 = {st.koi8, 1'b0};

  always_comb begin
    if (st.ge3 && st.lead0 == ted_pkg::BOM8_0 && st.lead1 == ted_pkg::BOM8_1
        && st.lead2 == ted_pkg::BOM8_2) begin
      enc = ted_pkg::ENC_UTF8;
    end else if (st.ge2 && st.lead0 == ted_pkg::BOM16_FF
                 && st.lead1 == ted_pkg::BOM16_FE) begin
      enc = ted_pkg::ENC_UTF16LE;
    end else if (st.ge2 && st.lead0 == ted_pkg::BOM16_FE
                 && st.lead1 == ted_pkg::BOM16_FF) begin
      enc = ted_pkg::ENC_UTF16BE;
    end else if (!st.high_seen) begin
      enc = ted_pkg::ENC_ASCII;
    end else if (st.utf8 > {1'b0, st.cp1251} && st.utf8 > {1'b0, st.koi8}) begin
      enc = ted_pkg::ENC_UTF8;
    end else if ({1'b0, st.koi8} > cp_x2) begin
      enc = ted_pkg::ENC_KOI8R;
    end else if ({1'b0, st.cp1251} > koi_x2) begin
      enc = ted_pkg::ENC_CP1251;
    end else begin
      enc = ted_pkg::ENC_UTF8;
    end
  end

endmodule

FILE: rtl/text_encoding_detector_top.sv
// Text encoding detector.
// Input channel (in_valid/in_ready): one file byte per transfer, data_byte,
// with last_byte high on the file's final byte. The block keeps the first
// three bytes for a byte-order-mark check, flags any byte above 0x7F in the
// first scan_limit bytes and scores lead/continuation pairs for UTF-8,
// KOI8-R and WINDOWS-1251 over the first sample_limit scoring steps.
// Output channel (out_valid/out_ready): one transfer of encoding per file,
// produced from the final byte; no other byte gives a result.
// Latency: the code is presented the cycle after the final byte's transfer.
// Throughput: one byte per clock; the state update and decision are one
// short pass between the stream registers and the output register.
// Stall: the output register holds its code while out_ready is low; a new
// byte is still taken whenever the output register is empty or being
// drained in the same cycle.
// Configuration (cfg_valid/cfg_ready, always ready): cfg_index 0 writes
// scan_limit (12 bits), 1 writes sample_limit (8 bits); other indexes are
// ignored. Write only while no file is in flight.
// Reset (rst, synchronous): stream state cleared, limits back to 1000/100,
// output empty. After each final byte the stream state clears for the next
// file.
module text_encoding_detector_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        data_byte,
  input  logic                              last_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        encoding,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ted_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ted_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration
  logic [ted_pkg::POS_W-1:0]    scan_limit;
  logic [ted_pkg::SAMPLE_W-1:0] sample_limit;

  // stream state
  logic [ted_pkg::POS_W-1:0]    byte_position;
  logic [7:0]                   lead0, lead1, lead2;
  logic                         high_byte_seen;
  logic [ted_pkg::SAMPLE_W-1:0] sample_steps;
  logic                         lead_pending;
  logic [ted_pkg::UTF8_W-1:0]   utf8_score;
  logic [ted_pkg::SCORE_W-1:0]  cp1251_score;
  logic [ted_pkg::SCORE_W-1:0]  koi8_score;

  logic [ted_pkg::POS_W-1:0]    byte_position_next;
  logic [7:0]                   lead0_next, lead1_next, lead2_next;
  logic                         high_byte_seen_next;
  logic [ted_pkg::SAMPLE_W-1:0] sample_steps_next;
  logic                         lead_pending_next;
  logic [ted_pkg::UTF8_W-1:0]   utf8_score_next;
  logic [ted_pkg::SCORE_W-1:0]  cp1251_score_next;
  logic [ted_pkg::SCORE_W-1:0]  koi8_score_next;

  logic in_xfer, out_xfer;
  logic is_lead, is_cont, is_koi, do_single;
  ted_pkg::stream_t st;
  ted_pkg::enc_t    enc;

  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    is_lead = data_byte inside {[8'hC0:8'hDF]};
    is_cont = data_byte inside {[8'h80:8'hBF]};
    is_koi  = data_byte >= 8'hE0;

    lead0_next = (byte_position == 12'd0) ? data_byte : lead0;
    lead1_next = (byte_position == 12'd1) ? data_byte : lead1;
    lead2_next = (byte_position == 12'd2) ? data_byte : lead2;

    high_byte_seen_next = high_byte_seen
                          || (byte_position < scan_limit && data_byte[7]);
    byte_position_next = (byte_position < ted_pkg::POS_MAX)
                         ? byte_position + 12'd1 : byte_position;

    sample_steps_next = sample_steps;
    lead_pending_next = lead_pending;
    utf8_score_next   = utf8_score;
    do_single         = 1'b0;
    if (lead_pending) begin
      // second byte of a pair completes the step
      lead_pending_next = 1'b0;
      if (is_cont) begin
        utf8_score_next = utf8_score + 9'd2;
      end else begin
        do_single = 1'b1;
      end
    end else if (sample_steps < sample_limit) begin
      sample_steps_next = sample_steps + 8'd1;
      if (is_lead) begin
        lead_pending_next = 1'b1;
      end else begin
        do_single = 1'b1;
      end
    end

    koi8_score_next   = koi8_score + {7'd0, do_single && is_koi};
    // a lead still open at end of file counts for CP1251
    cp1251_score_next = cp1251_score
                        + {7'd0, (do_single && is_lead) || (last_byte && lead_pending_next)};
  end

  always_comb begin
    st.ge2       = byte_position_next >= 12'd2;
    st.ge3       = byte_position_next >= 12'd3;
    st.lead0     = lead0_next;
    st.lead1     = lead1_next;
    st.lead2     = lead2_next;
    st.high_seen = high_byte_seen_next;
    st.utf8      = utf8_score_next;
    st.cp1251    = cp1251_score_next;
    st.koi8      = koi8_score_next;
  end

  ted_decide u_decide (
    .st  (st),
    .enc (enc)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit   <= ted_pkg::SCAN_LIMIT_RESET;
      sample_limit <= ted_pkg::SAMPLE_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ted_pkg::CFG_SCAN_LIMIT:   scan_limit   <= cfg_data;
        ted_pkg::CFG_SAMPLE_LIMIT: sample_limit <= cfg_data[ted_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // leading bytes: payload only, guarded by byte_position
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lead0 <= lead0_next;
      lead1 <= lead1_next;
      lead2 <= lead2_next;
    end
  end

  // stream counters and scores
  always_ff @(posedge clk) begin
    if (rst || (in_xfer && last_byte)) begin
      byte_position  <= '0;
      high_byte_seen <= 1'b0;
      sample_steps   <= '0;
      lead_pending   <= 1'b0;
      utf8_score     <= '0;
      cp1251_score   <= '0;
      koi8_score     <= '0;
    end else if (in_xfer) begin
      byte_position  <= byte_position_next;
      high_byte_seen <= high_byte_seen_next;
      sample_steps   <= sample_steps_next;
      lead_pending   <= lead_pending_next;
      utf8_score     <= utf8_score_next;
      cp1251_score   <= cp1251_score_next;
      koi8_score     <= koi8_score_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && last_byte) begin
      encoding <= enc;
    end
  end

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer && last_byte |=> out_valid)
    else $error("final byte did not load a result");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    in_xfer && last_byte |=> byte_position == '0 && sample_steps == '0
                             && !lead_pending && !high_byte_seen)
    else $error("stream state not cleared after final byte");

  a_lead_needs_step: assert property (@(posedge clk) disable iff (rst)
    lead_pending |-> sample_steps != '0)
    else $error("lead pending without a started step");

  a_utf8_even: assert property (@(posedge clk) disable iff (rst)
    utf8_score[0] == 1'b0)
    else $error("UTF-8 score odd");
`endif

endmodule

FILE: bench/encoding_checker.sv
`timescale 1ns / 1ps

// Watches the byte, result and register channels and predicts the encoding
// code of every file. Each result transfer is compared with the oldest code owed.
module encoding_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [2:0]                     encoding,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ted_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ted_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             codes_owed
);

  localparam logic [7:0] ASCII_TOP = 8'h7F;
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;
  localparam logic [7:0] LEAD_LO   = 8'hC0;
  localparam logic [7:0] LEAD_HI   = 8'hDF;
  localparam logic [7:0] KOI8_LO   = 8'hE0;

  localparam logic [ted_pkg::POS_W-1:0]    POS_ONE   = 1;
  localparam logic [ted_pkg::POS_W-1:0]    POS_TWO   = 2;
  localparam logic [ted_pkg::POS_W-1:0]    POS_THREE = 3;
  localparam logic [ted_pkg::SAMPLE_W-1:0] STEP_ONE  = 1;
  localparam logic [ted_pkg::SCORE_W-1:0]  SCORE_ONE = 1;
  localparam logic [ted_pkg::UTF8_W-1:0]   UTF8_TWO  = 2;

  logic [ted_pkg::POS_W-1:0]    scan_lim;
  logic [ted_pkg::SAMPLE_W-1:0] sample_lim;

  // per-file state
  logic [ted_pkg::POS_W-1:0]    seen_count;
  logic [7:0]                   head_bytes [0:2];
  logic                         non_ascii;
  logic [ted_pkg::SAMPLE_W-1:0] steps_begun;
  logic                         lead_open;
  logic [ted_pkg::UTF8_W-1:0]   utf8_pts;
  logic [ted_pkg::SCORE_W-1:0]  cp1251_pts;
  logic [ted_pkg::SCORE_W-1:0]  koi8_pts;

  ted_pkg::enc_t owed_codes [$];
  ted_pkg::enc_t want;

  initial begin
    mismatches = 0;
    codes_owed = 0;
  end

  function automatic void clear_file();
    seen_count  = '0;
    head_bytes[0] = '0;
    head_bytes[1] = '0;
    head_bytes[2] = '0;
    non_ascii   = 1'b0;
    steps_begun = '0;
    lead_open   = 1'b0;
    utf8_pts    = '0;
    cp1251_pts  = '0;
    koi8_pts    = '0;
  endfunction

  function automatic void score_lone(input logic [7:0] b);
    if (b >= KOI8_LO) begin
      koi8_pts = koi8_pts + SCORE_ONE;
    end else if (b >= LEAD_LO) begin
      cp1251_pts = cp1251_pts + SCORE_ONE;
    end
  endfunction

  function automatic ted_pkg::enc_t classify();
    if (seen_count >= POS_THREE && head_bytes[0] == ted_pkg::BOM8_0
        && head_bytes[1] == ted_pkg::BOM8_1 && head_bytes[2] == ted_pkg::BOM8_2) begin
      return ted_pkg::ENC_UTF8;
    end
    if (seen_count >= POS_TWO && head_bytes[0] == ted_pkg::BOM16_FF
        && head_bytes[1] == ted_pkg::BOM16_FE) begin
      return ted_pkg::ENC_UTF16LE;
    end
    if (seen_count >= POS_TWO && head_bytes[0] == ted_pkg::BOM16_FE
        && head_bytes[1] == ted_pkg::BOM16_FF) begin
      return ted_pkg::ENC_UTF16BE;
    end
    if (!non_ascii) begin
      return ted_pkg::ENC_ASCII;
    end
    if (utf8_pts > {1'b0, cp1251_pts} && utf8_pts > {1'b0, koi8_pts}) begin
      return ted_pkg::ENC_UTF8;
    end
    if (int'(koi8_pts) > 2 * int'(cp1251_pts)) begin
      return ted_pkg::ENC_KOI8R;
    end
    if (int'(cp1251_pts) > 2 * int'(koi8_pts)) begin
      return ted_pkg::ENC_CP1251;
    end
    return ted_pkg::ENC_UTF8;
  endfunction

  function automatic void absorb(input logic [7:0] b, input logic fin);
    if (seen_count < POS_THREE) begin
      head_bytes[seen_count[1:0]] = b;
    end
    if (seen_count < scan_lim && b > ASCII_TOP) begin
      non_ascii = 1'b1;
    end
    if (seen_count != ted_pkg::POS_MAX) begin
      seen_count = seen_count + POS_ONE;
    end
    if (lead_open) begin
      // second byte of a step
      lead_open = 1'b0;
      if (b >= CONT_LO && b <= CONT_HI) begin
        utf8_pts = utf8_pts + UTF8_TWO;
      end else begin
        score_lone(b);
      end
    end else if (steps_begun < sample_lim) begin
      steps_begun = steps_begun + STEP_ONE;
      if (b >= LEAD_LO && b <= LEAD_HI) begin
        lead_open = 1'b1;
      end else begin
        score_lone(b);
      end
    end
    if (fin) begin
      // lead byte left hanging at the end counts as cp1251
      if (lead_open) begin
        cp1251_pts = cp1251_pts + SCORE_ONE;
      end
      owed_codes.push_back(classify());
      clear_file();
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      scan_lim   = ted_pkg::SCAN_LIMIT_RESET;
      sample_lim = ted_pkg::SAMPLE_LIMIT_RESET;
      clear_file();
      owed_codes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_codes.size() == 0) begin
          $error("encoding: expected none, got %0d", encoding);
          mismatches++;
        end else begin
          want = owed_codes.pop_front();
          if (encoding !== want) begin
            $error("encoding: expected %0d, got %0d", want, encoding);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ted_pkg::CFG_SCAN_LIMIT) begin
          scan_lim = cfg_data[ted_pkg::POS_W-1:0];
        end else if (cfg_index == ted_pkg::CFG_SAMPLE_LIMIT) begin
          sample_lim = cfg_data[ted_pkg::SAMPLE_W-1:0];
        end
      end
      if (in_valid && in_ready) begin
        absorb(data_byte, last_byte);
      end
    end
    codes_owed = owed_codes.size();
  end

endmodule

FILE: bench/tb_text_encoding_detector_top.sv
`timescale 1ns / 1ps

module tb_text_encoding_detector_top;

  // Slowest run: ~2k bytes with drawn gaps, results behind drawn stalls,
  // and two receiver hold-offs.
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE      = 4;
  localparam int LONG_LEN    = 300;

  // index the block does not decode; a write there must change nothing
  localparam logic [ted_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {
    FL_ASCII, FL_UTF8, FL_KOI8, FL_CP1251, FL_MARK, FL_NOISE
  } flavour_t;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic [7:0]                     data_byte;
  logic                           last_byte;
  logic                           out_valid;
  logic                           out_ready;
  logic [2:0]                     encoding;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [ted_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ted_pkg::CFG_DATA_W-1:0] cfg_data;

  int   fail_count;
  int   codes_owed;
  int   cycle_count;
  logic steady;     // no idling on either side while set
  logic hold_req;   // asks the receiver for one long hold-off

  logic [7:0] file_buf [$];

  text_encoding_detector_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .encoding  (encoding),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  encoding_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .encoding   (encoding),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (fail_count),
    .codes_owed (codes_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: draws a random stall per result, then keeps ready high
  // until a transfer. On request it holds off for a long stretch so the
  // output register fills and the block stops taking bytes.
  initial begin
    int stall;
    int held;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk);
        out_ready <= 1'b0;
        held = 1;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
      end
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
    end
  end

  // One byte transfer. Valid drops only for a drawn gap, so a byte offered
  // straight after the previous one keeps valid high across the edge.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
  endtask

  task automatic send_file();
    int n;
    n = file_buf.size();
    for (int i = 0; i < n; i++) begin
      send_byte(file_buf[i], i == n - 1);
    end
    file_buf.delete();
  endtask

  // Quiet point for register writes: valid dropped, every code in, then a settle wait.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (codes_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ted_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ted_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input int scan, input int sample);
    wait_idle();
    write_reg(ted_pkg::CFG_SCAN_LIMIT, scan[ted_pkg::CFG_DATA_W-1:0]);
    write_reg(ted_pkg::CFG_SAMPLE_LIMIT, sample[ted_pkg::CFG_DATA_W-1:0]);
  endtask

  // Well-formed files of one flavour with random content; noise files mixed in.
  task automatic build_file(input flavour_t fl, input int len);
    int k;
    logic [7:0] b;
    k = 0;
    if (fl == FL_MARK) begin
      case ($urandom_range(0, 2))
        0: file_buf = '{ted_pkg::BOM8_0, ted_pkg::BOM8_1, ted_pkg::BOM8_2};
        1: file_buf = '{ted_pkg::BOM16_FF, ted_pkg::BOM16_FE};
        default: file_buf = '{ted_pkg::BOM16_FE, ted_pkg::BOM16_FF};
      endcase
      // sometimes cut the mark short
      if ($urandom_range(0, 3) == 0) file_buf.pop_back();
      k = file_buf.size();
    end
    while (k < len) begin
      b = 8'($urandom_range(0, 255));
      case (fl)
        FL_ASCII:  b = 8'($urandom_range(0, 127));
        FL_UTF8: begin
          if ($urandom_range(0, 1) == 0 && k + 1 < len) begin
            file_buf.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            k++;
            b = 8'($urandom_range(8'h80, 8'hBF));
          end else begin
            b = 8'($urandom_range(8'h20, 8'h7E));
          end
        end
        FL_KOI8:   b = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(8'hE0, 8'hFF))
                                                   : 8'($urandom_range(0, 127));
        FL_CP1251: b = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(8'hC0, 8'hDF))
                                                   : 8'($urandom_range(0, 8'hFF));
        default: ;
      endcase
      file_buf.push_back(b);
      k++;
    end
  endtask

  // Random phase: new limits, then files until the byte budget is spent.
  task automatic random_phase(input int budget, input logic hold);
    int sent;
    int len;
    int scan;
    int sample;
    flavour_t fl;
    scan   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 24);
    sample = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
    set_limits(scan, sample);
    steady = ($urandom_range(0, 3) == 0);
    if (hold) begin
      hold_req = 1'b1;
    end
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 16);
      fl  = ($urandom_range(0, 4) == 0) ? FL_NOISE : flavour_t'($urandom_range(0, 4));
      build_file(fl, len);
      sent += file_buf.size();
      send_file();
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ted_pkg::CFG_SCAN_LIMIT;
    cfg_data  = '0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed files at the reset limits.
    file_buf = '{8'hEF, 8'hBB, 8'hBF, 8'h41}; send_file();   // utf-8 mark
    file_buf = '{8'hEF, 8'hBB};               send_file();   // mark cut short
    file_buf = '{8'hFF, 8'hFE, 8'h00};        send_file();   // utf-16le
    file_buf = '{8'hFE, 8'hFF};               send_file();   // utf-16be
    file_buf = '{8'hFF};                      send_file();   // one byte, no mark
    file_buf = '{8'h00, 8'h7F};               send_file();   // plain ascii
    file_buf = '{8'hD0, 8'hB0, 8'hD1, 8'h81}; send_file();   // utf-8 pairs
    file_buf = '{8'hE1, 8'hF2, 8'hFF};        send_file();   // koi8-r
    file_buf = '{8'hC0, 8'hDF, 8'hC1, 8'h20}; send_file();   // cp1251
    file_buf = '{8'h41, 8'hC5};               send_file();   // lead left pending
    file_buf = '{8'hE0, 8'hC0, 8'hC0};        send_file();   // tied scores

    // Zero limits: nothing checked, nothing scored.
    set_limits(0, 0);
    file_buf = '{8'hC0, 8'hE0, 8'h80};        send_file();
    file_buf = '{8'hFE, 8'hFF, 8'h80};        send_file();

    // Smallest nonzero limits: only the first byte checked, one step scored.
    set_limits(1, 1);
    file_buf = '{8'h41, 8'hE0};               send_file();
    file_buf = '{8'hE0, 8'hD0, 8'hB0, 8'hD0, 8'hB0}; send_file();

    // Largest limits, a write to an undecoded index, then a longer file
    // whose high bytes come only after the first 256.
    set_limits(4095, 255);
    write_reg(CFG_SPARE, '1);
    for (int i = 0; i < LONG_LEN; i++) begin
      file_buf.push_back(i >= 256 ? 8'($urandom_range(8'h80, 8'hFF)) : 8'h41);
    end
    steady = 1'b1;
    send_file();
    steady = 1'b0;

    // Random part; two phases with a long receiver hold-off.
    for (int p = 0; p < 8; p++) begin
      random_phase(200, p == 2 || p == 6);
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
